FILE: rtl/core/hrfp_pkg.sv
// ----------------------------------------------------------------------------
// hrfp_pkg
// Shared types and constants of the display reply frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrfp_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] ACK_K      = 8'h4B;
    localparam logic [7:0] ACK_FF     = 8'hFF;
    localparam logic [7:0] NAK_N      = 8'h4E;

    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_INIT     = 2'd1;
    localparam logic [1:0] CMD_ARM_INFO = 2'd2;
    localparam logic [1:0] CMD_ARM_ACK  = 2'd3;

    localparam logic [2:0] LS_SETUP = 3'd1;
    localparam logic [2:0] LS_ABORT = 3'd3;
    localparam logic [2:0] LS_IDLE  = 3'd4;
    localparam logic [2:0] LS_ERROR = 3'd5;
    localparam logic [2:0] LS_OTHER = 3'd6;

    localparam logic [1:0] FS_NONE     = 2'd0;
    localparam logic [1:0] FS_MATCH    = 2'd1;
    localparam logic [1:0] FS_MISMATCH = 2'd2;

    typedef enum logic [2:0] {
        PH_READY,
        PH_DETECT,
        PH_DATA,
        PH_SUM_L,
        PH_SUM_H
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_FETCH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic rd_first;
        logic rd_next;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic at_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/hrfp_ram.sv
// ----------------------------------------------------------------------------
// hrfp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hrfp_ctrl.sv
// ----------------------------------------------------------------------------
// hrfp_ctrl
// Sequencer: takes an item, presents its result, walks the payload out.
// ----------------------------------------------------------------------------
`default_nettype none

module hrfp_ctrl
    import hrfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.emit ? ST_FETCH : ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready && status.at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.take     = 1'b0;
        cmd.rd_first = 1'b0;
        cmd.rd_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.take     = in_valid;
                cmd.rd_first = in_valid && status.emit;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
            end
            ST_FETCH:
            begin
                out_valid = 1'b0;
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.rd_next = out_ready && !status.at_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == ST_RESP || state_reg == ST_FETCH))
        else $error("item taken without a result following");

    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_ready && status.at_last) |=> in_ready)
        else $error("payload end did not release the input");

endmodule

`default_nettype wire

FILE: rtl/core/hrfp_dp.sv
// ----------------------------------------------------------------------------
// hrfp_dp
// Reply parser datapath: receive phase, frame store, checksum, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module hrfp_dp
    import hrfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    input  wire logic [1:0] cmd_code,
    input  wire logic [7:0] rx_byte,
    input  wire logic [2:0] link_state,
    input  wire logic       emitting,
    output logic      [2:0] link_state_out,
    output logic            connected,
    output logic      [1:0] frame_status,
    output logic            payload_valid,
    output logic      [7:0] payload_byte,
    output logic            last
);

    phase_t            phase_reg,  phase_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [15:0]       sum_reg,    sum_next;
    logic [7:0]        sum_low_reg, sum_low_next;
    logic              conn_reg,   conn_next;
    logic [2:0]        ls_reg,     ls_next;
    logic [1:0]        fs_reg,     fs_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;

    phase_t            eff_phase;
    logic [2:0]        ls_in;
    logic              store_we;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rd_data;
    logic              emit;

    always_comb
    begin
        ls_in        = (link_state == 3'd7) ? LS_OTHER : link_state;
        eff_phase    = phase_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        sum_low_next = sum_low_reg;
        conn_next    = conn_reg;
        ls_next      = ls_in;
        fs_next      = FS_NONE;
        store_we     = 1'b0;
        emit         = 1'b0;
        case (cmd_code)
            CMD_INIT:
            begin
                conn_next = 1'b0;
                ls_next   = LS_SETUP;
            end
            CMD_ARM_INFO:
            begin
                phase_next = PH_DETECT;
            end
            CMD_ARM_ACK:
            begin
                phase_next = PH_READY;
            end
            default:
            begin
                if (ls_in == LS_SETUP && phase_reg == PH_READY)
                begin
                    eff_phase = PH_DETECT;
                end
                phase_next = eff_phase;
                case (eff_phase)
                    PH_DETECT:
                    begin
                        if (rx_byte == START_BYTE)
                        begin
                            count_next = CNT_W'(1);
                            sum_next   = {8'd0, rx_byte};
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = sum_reg + {8'd0, rx_byte};
                        if (count_next == CNT_W'(FRAME_BYTES))
                        begin
                            phase_next = PH_SUM_L;
                        end
                    end
                    PH_SUM_L:
                    begin
                        sum_low_next = rx_byte;
                        phase_next   = PH_SUM_H;
                    end
                    PH_SUM_H:
                    begin
                        phase_next = PH_DETECT;
                        if ({rx_byte, sum_low_reg} == sum_reg)
                        begin
                            fs_next   = FS_MATCH;
                            conn_next = 1'b1;
                            if (ls_in == LS_SETUP)
                            begin
                                emit    = 1'b1;
                                ls_next = LS_ABORT;
                            end
                        end
                        else
                        begin
                            fs_next = FS_MISMATCH;
                        end
                    end
                    default:
                    begin
                        if (rx_byte == ACK_K || rx_byte == ACK_FF)
                        begin
                            ls_next = LS_IDLE;
                        end
                        else if (rx_byte == NAK_N)
                        begin
                            ls_next = LS_ERROR;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_READY;
            count_reg   <= '0;
            sum_reg     <= '0;
            sum_low_reg <= '0;
            conn_reg    <= 1'b0;
        end
        else if (cmd.take)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            sum_low_reg <= sum_low_next;
            conn_reg    <= conn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ls_reg <= ls_next;
            fs_reg <= fs_next;
        end
        if (rd_en)
        begin
            idx_reg <= idx_next;
        end
    end

    assign idx_next = cmd.rd_first ? ADDR_W'(1) : idx_reg + ADDR_W'(1);
    assign raddr    = idx_next;
    assign rd_en    = cmd.rd_first || cmd.rd_next;

    hrfp_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.take && store_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign status.emit    = emit;
    assign status.at_last = (idx_reg == ADDR_W'(FRAME_BYTES - 1));

    assign link_state_out = ls_reg;
    assign connected      = conn_reg;
    assign frame_status   = fs_reg;
    assign payload_valid  = emitting;
    assign payload_byte   = emitting ? rd_data : 8'd0;
    assign last           = emitting ? status.at_last : 1'b1;

    a_first_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_first |=> (idx_reg == ADDR_W'(1)))
        else $error("payload walk did not start after the start byte");

    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && emit) |=> (ls_reg == LS_ABORT && fs_reg == FS_MATCH && conn_reg))
        else $error("payload frame without matched checksum");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (count_reg < CNT_W'(FRAME_BYTES)))
        else $error("byte count beyond frame length in data phase");

endmodule

`default_nettype wire

FILE: rtl/core/hud_reply_frame_parser_core.sv
// ----------------------------------------------------------------------------
// hud_reply_frame_parser_core
// Reply parser for a UART-attached display unit: acknowledge decoding,
// checksummed info frame capture and payload delivery in setup state.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_ready  cmd, rx_byte, link_state
//   out      out_valid/ out_ready link_state_out, connected, frame_status,
//                                 payload_valid, payload_byte, last
//
// A taken item's single result shows the next cycle, but a good frame in
// setup state gives FRAME_BYTES-1 results: a fetch state waits on the first
// store read, then one byte per cycle follows while out_ready is high.
// No item is taken while any result of the previous one is still pending.
// Stalls on out_ready hold the result; rst_n clears phase, counts and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hud_reply_frame_parser_core
    import hrfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] rx_byte,
    input  wire logic [2:0] link_state,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [2:0] link_state_out,
    output logic            connected,
    output logic      [1:0] frame_status,
    output logic            payload_valid,
    output logic      [7:0] payload_byte,
    output logic            last
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       emitting;
    logic       ready_int;
    logic       valid_int;
    logic       emit_phase_reg;
    logic       emit_phase;

    hrfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (ready_int),
        .out_valid (valid_int),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    assign emitting = valid_int && emit_phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_phase_reg <= 1'b0;
        end
        else if (dp_cmd.rd_first)
        begin
            emit_phase_reg <= 1'b1;
        end
        else if (ready_int)
        begin
            emit_phase_reg <= 1'b0;
        end
    end

    assign emit_phase = emit_phase_reg;

    hrfp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .cmd_code       (cmd),
        .rx_byte        (rx_byte),
        .link_state     (link_state),
        .emitting       (emitting),
        .link_state_out (link_state_out),
        .connected      (connected),
        .frame_status   (frame_status),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .last           (last)
    );

    assign in_ready  = ready_int;
    assign out_valid = valid_int;

endmodule

`default_nettype wire
